[rtl/lmk_pkg.sv]
`timescale 1ns / 1ps

package lmk_pkg;

  typedef enum logic [1:0] {
    EV_SHORT = 2'd0,
    EV_LONG  = 2'd1,
    EV_KNOB  = 2'd2,
    EV_NONE  = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    CM_NORMAL = 2'd0,
    CM_STROBE = 2'd1,
    CM_FLASH  = 2'd2,
    CM_FADE   = 2'd3
  } color_mode_t;

  localparam logic [1:0] REG_COLOR     = 2'd0;
  localparam logic [1:0] REG_SPEED     = 2'd1;
  localparam logic [1:0] REG_INTENSITY = 2'd2;

  localparam logic [23:0] COLOR_RST     = 24'd0;
  localparam logic [9:0]  SPEED_RST     = 10'd512;
  localparam logic [7:0]  INTENSITY_RST = 8'd255;
  localparam logic [7:0]  QUARTER_RST   = 8'd1;

  localparam logic [9:0] HUE_SEG1  = 10'd341;
  localparam logic [9:0] HUE_SEG2  = 10'd682;
  localparam logic [9:0] HUE_SEG2B = 10'd683;

  typedef struct packed {
    logic        color_we;
    logic        speed_we;
    logic        intensity_we;
    logic [23:0] color;
    logic [9:0]  speed;
    logic [7:0]  intensity;
  } cfg_wr_t;

  typedef struct packed {
    logic        white_on;
    logic        rgb_on;
    logic [1:0]  rgb_mode;
    logic [23:0] color;
    logic [9:0]  speed;
    logic [7:0]  intensity;
  } result_t;

endpackage

[rtl/lmk_hue.sv]
`timescale 1ns / 1ps

module lmk_hue (
  input  logic [9:0]  knob,
  output logic [23:0] color
);
  import lmk_pkg::*;

  logic [1:0]  seg;
  logic [9:0]  ofs;
  logic [10:0] ofs3;
  logic [7:0]  v;
  logic [7:0]  v_inv;

  always_comb begin
    if (knob < HUE_SEG1) begin
      seg = 2'd0;
      ofs = knob;
    end else if (knob < HUE_SEG2) begin
      seg = 2'd1;
      ofs = knob - HUE_SEG1;
    end else begin
      seg = 2'd2;
      // knob 682 sits between segments and maps to zero
      ofs = (knob >= HUE_SEG2B) ? (knob - HUE_SEG2B) : 10'd0;
    end
    ofs3  = {1'b0, ofs} + {ofs, 1'b0};
    v     = ofs3[9:2];
    v_inv = 8'(~v + 8'd1);
    case (seg)
      2'd0:    color = {v_inv, v, 8'd1};
      2'd1:    color = {8'd1, v_inv, v};
      default: color = {v, 8'd1, v_inv};
    endcase
  end

endmodule

[rtl/lmk_cfg.sv]
`timescale 1ns / 1ps

module lmk_cfg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output lmk_pkg::cfg_wr_t cfg_wr
);
  import lmk_pkg::*;

  logic [23:0] color_r;
  logic [9:0]  speed_r;
  logic [7:0]  intensity_r;
  logic        wr_en;
  logic [1:0]  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_comb begin
    cfg_wr              = '0;
    cfg_wr.color        = pwdata[23:0];
    cfg_wr.speed        = pwdata[9:0];
    cfg_wr.intensity    = pwdata[7:0];
    unique case (idx)
      REG_COLOR:     cfg_wr.color_we     = wr_en;
      REG_SPEED:     cfg_wr.speed_we     = wr_en;
      REG_INTENSITY: cfg_wr.intensity_we = wr_en;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r     <= COLOR_RST;
      speed_r     <= SPEED_RST;
      intensity_r <= INTENSITY_RST;
    end else begin
      if (cfg_wr.color_we)     color_r     <= cfg_wr.color;
      if (cfg_wr.speed_we)     speed_r     <= cfg_wr.speed;
      if (cfg_wr.intensity_we) intensity_r <= cfg_wr.intensity;
    end
  end

  always_comb begin
    unique case (idx)
      REG_COLOR:     prdata = {8'd0, color_r};
      REG_SPEED:     prdata = {22'd0, speed_r};
      REG_INTENSITY: prdata = {24'd0, intensity_r};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

[rtl/lmk_core.sv]
`timescale 1ns / 1ps

module lmk_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic [1:0]       mode,
  input  logic [9:0]       knob,
  input  lmk_pkg::cfg_wr_t cfg_wr,
  output lmk_pkg::result_t state_nxt
);
  import lmk_pkg::*;

  logic        white_r, white_nxt;
  logic        rgb_r, rgb_nxt;
  color_mode_t cmode_r, cmode_nxt;
  logic [7:0]  quarter_r, quarter_nxt;
  logic [23:0] color_r, color_nxt;
  logic [9:0]  speed_r, speed_nxt;
  logic [7:0]  intensity_r, intensity_nxt;
  logic [23:0] hue_color;
  logic [7:0]  q;

  lmk_hue u_hue (
    .knob  (knob),
    .color (hue_color)
  );

  assign q = knob[9:2];

  always_comb begin
    white_nxt     = white_r;
    rgb_nxt       = rgb_r;
    cmode_nxt     = cmode_r;
    quarter_nxt   = quarter_r;
    color_nxt     = color_r;
    speed_nxt     = speed_r;
    intensity_nxt = intensity_r;
    if (step_en) begin
      case (event_t'(mode))
        EV_SHORT: begin
          if (!white_r && !rgb_r) begin
            white_nxt = 1'b1;
          end else if (!rgb_r) begin
            white_nxt = 1'b0;
            rgb_nxt   = 1'b1;
          end else if (cmode_r == CM_FADE) begin
            white_nxt = 1'b1;
            rgb_nxt   = 1'b0;
            cmode_nxt = CM_NORMAL;
          end else begin
            cmode_nxt = color_mode_t'(cmode_r + 2'd1);
          end
        end
        EV_LONG: begin
          white_nxt = 1'b0;
          rgb_nxt   = 1'b0;
        end
        EV_KNOB: begin
          // only a change of the upper eight bits counts as a new sample
          if (q != quarter_r) begin
            quarter_nxt = q;
            if (rgb_r) begin
              if (cmode_r == CM_NORMAL || cmode_r == CM_STROBE) color_nxt = hue_color;
              else speed_nxt = knob;
            end else begin
              intensity_nxt = q;
              white_nxt     = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    if (cfg_wr.color_we)     color_nxt     = cfg_wr.color;
    if (cfg_wr.speed_we)     speed_nxt     = cfg_wr.speed;
    if (cfg_wr.intensity_we) intensity_nxt = cfg_wr.intensity;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_r     <= 1'b1;
      rgb_r       <= 1'b0;
      cmode_r     <= CM_NORMAL;
      quarter_r   <= QUARTER_RST;
      color_r     <= COLOR_RST;
      speed_r     <= SPEED_RST;
      intensity_r <= INTENSITY_RST;
    end else begin
      white_r     <= white_nxt;
      rgb_r       <= rgb_nxt;
      cmode_r     <= cmode_nxt;
      quarter_r   <= quarter_nxt;
      color_r     <= color_nxt;
      speed_r     <= speed_nxt;
      intensity_r <= intensity_nxt;
    end
  end

  assign state_nxt.white_on  = white_nxt;
  assign state_nxt.rgb_on    = rgb_nxt;
  assign state_nxt.rgb_mode  = cmode_nxt;
  assign state_nxt.color     = color_nxt;
  assign state_nxt.speed     = speed_nxt;
  assign state_nxt.intensity = intensity_nxt;

endmodule

[rtl/led_mode_and_knob_controller.sv]
`timescale 1ns / 1ps

// RGBW strip mode and knob controller. Each event (short press, long press,
// knob sample) gives one result with the strip state after the event. One
// event is taken every cycle while in_stall is low; each event passes the
// input register, then the state update and result register. in_stall
// rises only while a result waits on out_stall with an event already held.
// Startup colour, speed and intensity are written over the APB port at
// byte addresses 0, 4 and 8; a write also loads the current value.

module led_mode_and_knob_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [9:0]  in_knob_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_white_on,
  output logic        out_rgb_on,
  output logic [1:0]  out_rgb_mode,
  output logic [23:0] out_color,
  output logic [9:0]  out_speed,
  output logic [7:0]  out_intensity,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lmk_pkg::*;

  logic       in_vld_r;
  logic [1:0] mode_r;
  logic [9:0] knob_r;
  logic       out_vld_r;
  result_t    res_r;
  result_t    state_nxt;
  cfg_wr_t    cfg_wr;
  logic       advance;
  logic       in_xfer;

  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  lmk_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_wr  (cfg_wr)
  );

  lmk_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .mode      (mode_r),
    .knob      (knob_r),
    .cfg_wr    (cfg_wr),
    .state_nxt (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_xfer)      in_vld_r <= 1'b1;
      else if (advance) in_vld_r <= 1'b0;
      if (advance)        out_vld_r <= 1'b1;
      else if (!out_stall) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r <= in_mode;
      knob_r <= in_knob_value;
    end
    if (advance) res_r <= state_nxt;
  end

  assign out_valid     = out_vld_r;
  assign out_white_on  = res_r.white_on;
  assign out_rgb_on    = res_r.rgb_on;
  assign out_rgb_mode  = res_r.rgb_mode;
  assign out_color     = res_r.color;
  assign out_speed     = res_r.speed;
  assign out_intensity = res_r.intensity;

endmodule
